// ===== design/fdf_pkg.sv =====
`default_nettype none
package fdf_pkg;

	localparam int TAPS_DEF       = 32;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int TAP_COUNT_W    = 6;
	localparam int COEF_IDX_W     = 5;
	localparam int FUNC_W         = 2;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(32);

	// register index taken from paddr[2]
	localparam logic REG_TAP_COUNT = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_FILTER = 2'd0,
		FUNC_LOAD   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef struct packed {
		logic                   shift;
		logic                   clear;
		logic                   coef_wr;
		logic [COEF_IDX_W-1:0]  coef_index;
		logic [TAP_COUNT_W-1:0] tap_count;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/fdf_cell.sv =====
`default_nettype none
module fdf_cell #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_W      = 37,
	parameter int INDEX      = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  fdf_pkg::cell_ctrl_t          ctrl,
	input  wire logic [DATA_WIDTH-1:0]   coef_value,
	input  wire logic [DATA_WIDTH-1:0]   sample_in,
	output logic [DATA_WIDTH-1:0]        sample_q,
	input  wire logic signed [ACC_W-1:0] sum_in,
	input  wire                          vld_in,
	output logic signed [ACC_W-1:0]      sum_q,
	output logic                         vld_q
);
	import fdf_pkg::*;

	logic signed [DATA_WIDTH-1:0]   coef_q;
	logic signed [2*DATA_WIDTH-1:0] prod_q;
	logic signed [ACC_W-1:0]        prod_ext;
	logic                           coef_hit;
	logic                           use_tap;

	assign coef_hit = ctrl.coef_wr && (32'(ctrl.coef_index) == 32'(INDEX));
	// tap count of zero still uses the first coefficient
	assign use_tap  = (INDEX == 0) || (32'(ctrl.tap_count) > 32'(INDEX));
	assign prod_ext = ACC_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			sample_q <= '0;
			vld_q    <= 1'b0;
		end else begin
			if (coef_hit) begin
				coef_q <= coef_value;
			end
			if (ctrl.clear) begin
				sample_q <= '0;
			end else if (ctrl.shift) begin
				sample_q <= sample_in;
			end
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= coef_q * $signed(sample_q);
		if (vld_in) begin
			sum_q <= use_tap ? (sum_in + prod_ext) : sum_in;
		end
	end

endmodule
`default_nettype wire

// ===== design/fdf_out.sv =====
`default_nettype none
module fdf_out #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_W      = 37
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire logic signed [ACC_W-1:0] sum,
	input  wire                          load,
	output logic                         free,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [DATA_WIDTH-1:0]        filtered,
	output logic                         saturated
);
	import fdf_pkg::*;

	localparam logic signed [ACC_W-1:0] MAX_V =
		{{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] MIN_V = ~MAX_V;

	logic signed [ACC_W-1:0] shifted;
	logic [DATA_WIDTH-1:0]   clip;
	logic                    clip_flag;
	logic                    valid_q;
	logic [DATA_WIDTH-1:0]   filtered_q;
	logic                    saturated_q;

	assign shifted = sum >>> (DATA_WIDTH - 1);

	always_comb begin
		clip      = shifted[DATA_WIDTH-1:0];
		clip_flag = 1'b0;
		if (shifted > MAX_V) begin
			clip      = MAX_V[DATA_WIDTH-1:0];
			clip_flag = 1'b1;
		end else if (shifted < MIN_V) begin
			clip      = MIN_V[DATA_WIDTH-1:0];
			clip_flag = 1'b1;
		end
	end

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			filtered_q  <= clip;
			saturated_q <= clip_flag;
		end
	end

	assign out_valid = valid_q;
	assign filtered  = filtered_q;
	assign saturated = saturated_q;

endmodule
`default_nettype wire

// ===== design/fir_direct_form_filter.sv =====
// result path: a sample transaction passes start_s1, start_s2, each cell's sum register, then the output register
// in_stall holds off the next transaction while the partial sum walks the cell chain, until its result is loaded
// coefficient load and history clear give no result
// a result waiting in the output register does not block the next transaction
// reset: coefficients and sample history cleared, tap_count set to 32, no result pending
`default_nettype none
module fir_direct_form_filter #(
	parameter int TAPS       = fdf_pkg::TAPS_DEF,
	parameter int DATA_WIDTH = fdf_pkg::DATA_WIDTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire logic [fdf_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [fdf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [fdf_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire logic [fdf_pkg::FUNC_W-1:0]      func,
	input  wire logic [DATA_WIDTH-1:0]           sample,
	input  wire logic [fdf_pkg::COEF_IDX_W-1:0]  coef_index,
	input  wire logic [DATA_WIDTH-1:0]           coef_value,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [DATA_WIDTH-1:0]                filtered,
	output logic                                 saturated
);
	import fdf_pkg::*;

	localparam int ACC_RAW = 2 * DATA_WIDTH + $clog2(TAPS);
	localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (DATA_WIDTH - 2);

	logic [TAP_COUNT_W-1:0] tap_count_q;
	logic                   cfg_wr;
	logic                   in_take;
	logic                   take_sample;
	logic                   take_load;
	logic                   take_clear;
	logic                   run_q;
	logic                   start_s1;
	logic                   start_s2;
	logic                   done_q;
	logic                   pend;
	logic                   load;
	logic                   out_free;
	cell_ctrl_t             ctrl;

	logic [DATA_WIDTH-1:0]   samp [TAPS];
	logic signed [ACC_W-1:0] sums [TAPS];
	logic [TAPS-1:0]         vld_vec;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RST;
		end else if (cfg_wr && (paddr[2] == REG_TAP_COUNT)) begin
			tap_count_q <= pwdata[TAP_COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TAP_COUNT) begin
			prdata = APB_DATA_W'(tap_count_q);
		end
	end

	// input decode
	assign in_stall = run_q;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		take_sample = 1'b0;
		take_load   = 1'b0;
		take_clear  = 1'b0;
		case (func_t'(func))
			FUNC_FILTER: take_sample = in_take;
			FUNC_LOAD:   take_load   = in_take;
			FUNC_CLEAR:  take_clear  = in_take;
			default:     take_sample = 1'b0;
		endcase
	end

	assign ctrl.shift      = take_sample;
	assign ctrl.clear      = take_clear;
	assign ctrl.coef_wr    = take_load;
	assign ctrl.coef_index = coef_index;
	assign ctrl.tap_count  = tap_count_q;

	// start_s1 and start_s2 follow the sample and product registers, so the sum starts once the products are ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
			start_s2 <= 1'b0;
		end else begin
			start_s1 <= take_sample;
			start_s2 <= start_s1;
		end
	end

	generate
		for (genvar k = 0; k < TAPS; k++) begin : g_cell
			logic [DATA_WIDTH-1:0]   s_in;
			logic signed [ACC_W-1:0] a_in;
			logic                    v_in;

			if (k == 0) begin : g_head
				assign s_in = sample;
				assign a_in = ROUND;
				assign v_in = start_s2;
			end else begin : g_link
				assign s_in = samp[k-1];
				assign a_in = sums[k-1];
				assign v_in = vld_vec[k-1];
			end

			fdf_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.ACC_W      (ACC_W),
				.INDEX      (k)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.coef_value (coef_value),
				.sample_in  (s_in),
				.sample_q   (samp[k]),
				.sum_in     (a_in),
				.vld_in     (v_in),
				.sum_q      (sums[k]),
				.vld_q      (vld_vec[k])
			);
		end
	endgenerate

	// last cell holds its sum until the output register is free
	assign pend = vld_vec[TAPS-1] || done_q;
	assign load = pend && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			run_q  <= 1'b0;
		end else begin
			done_q <= pend && !out_free;
			if (take_sample) begin
				run_q <= 1'b1;
			end else if (load) begin
				run_q <= 1'b0;
			end
		end
	end

	fdf_out #(
		.DATA_WIDTH (DATA_WIDTH),
		.ACC_W      (ACC_W)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.sum        (sums[TAPS-1]),
		.load       (load),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.filtered   (filtered),
		.saturated  (saturated)
	);

	// only one partial sum in flight
	a_one_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_s1, start_s2, vld_vec, done_q}))
		else $error("more than one partial sum in flight");

	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		pend |-> run_q)
		else $error("result pending with no sample transaction running");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vld_vec[TAPS-1] |-> !done_q)
		else $error("new sum arrived while previous result still pending");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !run_q && !done_q)
		else $error("run flag not released after result load");

endmodule
`default_nettype wire
